@@ sv/assert_macros.svh @@
// assertion macros for the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ETOK_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ETOK_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ETOK_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/etok_pkg.sv @@
// shared types and constants of the expression tokenizer
`default_nettype none

package etok_pkg;

	localparam int ETOK_POS_WIDTH = 16;
	localparam int ETOK_QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_NAME = 3'd1,
		MODE_INT  = 3'd2,
		MODE_FRAC = 3'd3,
		MODE_SKIP = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_NUMBER  = 3'd0,
		KIND_NAME    = 3'd1,
		KIND_SYMBOL  = 3'd2,
		KIND_LPAREN  = 3'd3,
		KIND_RPAREN  = 3'd4,
		KIND_COMMA   = 3'd5,
		KIND_END     = 3'd6,
		KIND_UNKNOWN = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  head;
		logic        last;
	} token_t;

endpackage

`default_nettype wire

@@ sv/etok_lex.sv @@
// one-character lexer step: classification, token building and next scan state
`default_nettype none

module etok_lex #(
	parameter int POS_WIDTH = etok_pkg::ETOK_POS_WIDTH
) (
	input  var etok_pkg::mode_t   mode,
	input  wire [POS_WIDTH-1:0]   pos,
	input  wire [POS_WIDTH-1:0]   tok_begin,
	input  wire [7:0]             tok_head,
	input  wire [7:0]             c,
	output etok_pkg::mode_t       mode_nxt,
	output logic [POS_WIDTH-1:0]  pos_nxt,
	output logic [POS_WIDTH-1:0]  begin_nxt,
	output logic [7:0]            head_nxt,
	output etok_pkg::token_t      tok0,
	output etok_pkg::token_t      tok1,
	output logic [1:0]            tok_cnt
);
	import etok_pkg::*;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

	logic is_digit, is_alpha, is_space, is_sym;
	logic [POS_WIDTH-1:0] pos_inc, len_raw;
	logic [15:0] len_sat, pos_sat;
	token_t close_tok, char_tok;
	logic close_v, char_v, pending, skip;

	// character classes
	always_comb begin
		is_digit = (c >= 8'h30) && (c <= 8'h39);
		is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == 8'h5F);
		is_space = ((c >= 8'h09) && (c <= 8'h0D)) || (c == CH_SPACE);
		is_sym = (c == CH_PLUS) || (c == CH_STAR) || (c == CH_MINUS) || (c == CH_SLASH)
			|| (c == CH_EQUAL) || (c == CH_PIPE) || (c == CH_AMP) || (c == CH_TILDE);
	end

	// saturating position and pending token length
	assign pos_inc = (pos == POS_MAX) ? pos : pos + POS_WIDTH'(1);
	assign len_raw = pos - tok_begin;
	assign pos_sat = sat16(32'(pos));
	always_comb begin
		len_sat = sat16(32'(len_raw));
		if (len_sat == 16'd0) begin
			len_sat = 16'd1;
		end
	end

	// scan step
	always_comb begin
		mode_nxt = mode;
		pos_nxt = pos_inc;
		begin_nxt = tok_begin;
		head_nxt = tok_head;
		pending = 1'b0;
		skip = 1'b0;
		close_v = 1'b0;
		char_v = 1'b0;
		close_tok = '{kind: KIND_NAME, start: sat16(32'(tok_begin)), length: len_sat,
			head: tok_head, last: 1'b0};
		char_tok = '{kind: KIND_SYMBOL, start: pos_sat, length: 16'd1, head: c,
			last: 1'b0};

		// close or extend a pending name or number; in skip mode wait for the NUL
		unique case (mode)
			MODE_SKIP: begin
				skip = 1'b1;
				if (c == CH_NUL) begin
					mode_nxt = MODE_IDLE;
					pos_nxt = '0;
					begin_nxt = '0;
					head_nxt = '0;
				end
			end
			MODE_NAME: begin
				if (is_alpha || is_digit) begin
					pending = 1'b1;
				end else begin
					close_v = 1'b1;
				end
			end
			MODE_INT: begin
				if (is_digit) begin
					pending = 1'b1;
				end else if (c == CH_DOT) begin
					pending = 1'b1;
					mode_nxt = MODE_FRAC;
				end else begin
					close_v = 1'b1;
					close_tok.kind = KIND_NUMBER;
				end
			end
			MODE_FRAC: begin
				if (is_digit) begin
					pending = 1'b1;
				end else begin
					close_v = 1'b1;
					close_tok.kind = KIND_NUMBER;
				end
			end
			default: begin
			end
		endcase

		// classify the character itself
		if (!skip && !pending) begin
			mode_nxt = MODE_IDLE;
			priority if (c == CH_NUL) begin
				char_v = 1'b1;
				char_tok.kind = KIND_END;
				char_tok.head = 8'h00;
				char_tok.last = 1'b1;
				pos_nxt = '0;
				begin_nxt = '0;
				head_nxt = '0;
			end else if (is_space) begin
				char_v = 1'b0;
			end else if (c == CH_LPAREN) begin
				char_v = 1'b1;
				char_tok.kind = KIND_LPAREN;
			end else if (c == CH_RPAREN) begin
				char_v = 1'b1;
				char_tok.kind = KIND_RPAREN;
			end else if (c == CH_COMMA) begin
				char_v = 1'b1;
				char_tok.kind = KIND_COMMA;
			end else if (is_sym) begin
				char_v = 1'b1;
			end else if (is_alpha) begin
				mode_nxt = MODE_NAME;
				begin_nxt = pos;
				head_nxt = c;
			end else if (is_digit) begin
				mode_nxt = MODE_INT;
				begin_nxt = pos;
				head_nxt = c;
			end else begin
				char_v = 1'b1;
				char_tok.kind = KIND_UNKNOWN;
				char_tok.last = 1'b1;
				mode_nxt = MODE_SKIP;
			end
		end
	end

	// pack the tokens in emission order
	always_comb begin
		tok0 = close_v ? close_tok : char_tok;
		tok1 = char_tok;
		tok_cnt = {1'b0, close_v} + {1'b0, char_v};
	end

endmodule

`default_nettype wire

@@ sv/etok_queue.sv @@
// small token queue that takes up to two beats and gives one per cycle when popped
`default_nettype none

module etok_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire [1:0]         push_cnt,
	input  var etok_pkg::token_t tok0,
	input  var etok_pkg::token_t tok1,
	input  wire               pop,
	output etok_pkg::token_t  head,
	output logic              head_valid,
	output logic              room2
);
	import etok_pkg::*;

	localparam int DEPTH = ETOK_QUEUE_DEPTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	token_t entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head = entry_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);
	assign room2 = (cnt_q <= CW'(DEPTH - 2));

	// storage writes
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= tok0;
		end
		if (push_cnt == 2'd2) begin
			entry_q[wr_ptr_q + AW'(1)] <= tok1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ sv/expression_tokenizer.sv @@
// top level of the expression tokenizer
`default_nettype none

// Byte-serial lexer for arithmetic expressions. One character beat enters per
// cycle, unless stalled, into an input register; the scan step (character
// class, pending name or number, saturating position) runs combinationally
// from that register into a four-entry token queue. A character produces
// zero, one or two tokens; two come only when a character closes a pending
// name or number, and such a run always starts with a character that emitted
// nothing, so the queue never holds more than two tokens while the output is
// drained every cycle. The input side stalls only while the queue has fewer
// than two free entries, so the rate is one character per cycle without
// output stalls; under output stalls it follows the token drain. A NUL
// closes the string and emits an end token; after an unknown byte all input
// up to and including the next NUL is dropped. Tokens with last set (end,
// unknown) close the string.
module expression_tokenizer #(
	parameter int POS_WIDTH = etok_pkg::ETOK_POS_WIDTH
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        char_valid,
	output logic       char_stall,
	input  wire [7:0]  char_code,
	output logic       token_valid,
	input  wire        token_stall,
	output logic [2:0] token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [7:0] first_byte,
	output logic       last
);
	import etok_pkg::*;

	`include "assert_macros.svh"

	localparam logic [7:0] CH_NUL = 8'h00;

	logic valid_s1;
	logic [7:0] char_s1;
	mode_t mode_q, mode_nxt;
	logic [POS_WIDTH-1:0] pos_q, pos_nxt, begin_q, begin_nxt;
	logic [7:0] head_q, head_nxt;
	token_t tok0, tok1, q_head;
	logic [1:0] tok_cnt, push_cnt;
	logic room2, proc, accept, pop;
	logic last_kind_ok, nul_step;

	assign proc = valid_s1 && room2;
	assign char_stall = valid_s1 && !room2;
	assign accept = char_valid && !char_stall;
	assign push_cnt = proc ? tok_cnt : 2'd0;
	assign pop = token_valid && !token_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			begin_q <= '0;
			head_q <= '0;
		end else if (proc) begin
			mode_q <= mode_nxt;
			pos_q <= pos_nxt;
			begin_q <= begin_nxt;
			head_q <= head_nxt;
		end
	end

	etok_lex #(
		.POS_WIDTH(POS_WIDTH)
	) u_lex (
		.mode(mode_q),
		.pos(pos_q),
		.tok_begin(begin_q),
		.tok_head(head_q),
		.c(char_s1),
		.mode_nxt(mode_nxt),
		.pos_nxt(pos_nxt),
		.begin_nxt(begin_nxt),
		.head_nxt(head_nxt),
		.tok0(tok0),
		.tok1(tok1),
		.tok_cnt(tok_cnt)
	);

	etok_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_cnt(push_cnt),
		.tok0(tok0),
		.tok1(tok1),
		.pop(pop),
		.head(q_head),
		.head_valid(token_valid),
		.room2(room2)
	);

	// output fields
	assign token_kind = q_head.kind;
	assign token_start = q_head.start;
	assign token_length = q_head.length;
	assign first_byte = q_head.head;
	assign last = q_head.last;

	// check terms
	assign last_kind_ok = (token_kind == KIND_END) || (token_kind == KIND_UNKNOWN);
	assign nul_step = proc && (char_s1 == CH_NUL);

	// checks
	`ETOK_ASSERT_IMPLIES(a_stall_holds_item, clk, arst_n, char_stall, valid_s1)
	`ETOK_ASSERT_IMPLIES(a_last_kind, clk, arst_n, token_valid && last, last_kind_ok)
	`ETOK_ASSERT_NEXT(a_nul_restarts, clk, arst_n, nul_step, pos_q == '0 && mode_q == MODE_IDLE)
	`ETOK_ASSERT_IMPLIES(a_len_nonzero, clk, arst_n, token_valid, token_length != 16'd0)

endmodule

`default_nettype wire

@@ sim/expression_tokenizer_test.sv @@
// self-checking testbench for the expression tokenizer: directed and random strings
module expression_tokenizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import etok_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_CAP = 100;

	// character codes the scanner cares about
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic [7:0]  char_code = 8'h00;
	logic        token_stall = 1'b0;
	logic        char_stall;
	logic        token_valid;
	logic [2:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [7:0]  first_byte;
	logic        last;

	// scanner state mirrored by the testbench
	mode_t       lex_mode = MODE_IDLE;
	logic [15:0] lex_pos = '0;
	logic [15:0] lex_begin = '0;
	logic [7:0]  lex_head = '0;

	token_t      pending_tokens[$];
	int          lexed_chars = 0;
	int          burst_left = 0;
	int          errors = 0;
	int          idle_cycles = 0;
	logic [9:0]  stall_tick = '0;

	expression_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.token_start(token_start),
		.token_length(token_length),
		.first_byte(first_byte),
		.last(last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// character classes
	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_word_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	function automatic bit is_operator(input logic [7:0] c);
		return c == CH_PLUS || c == CH_STAR || c == CH_MINUS || c == CH_SLASH ||
			c == CH_EQUAL || c == CH_BAR || c == CH_AMP || c == CH_TILDE;
	endfunction

	task automatic clear_scan();
		lex_mode = MODE_IDLE;
		lex_pos = '0;
		lex_begin = '0;
		lex_head = '0;
	endtask

	// queue one token, length held at one or more
	task automatic push_token(input kind_t kind, input logic [15:0] start,
		input logic [15:0] len, input logic [7:0] head, input logic fin);
		token_t t;
		t.kind = kind;
		t.start = start;
		t.length = (len == 16'd0) ? 16'd1 : len;
		t.head = head;
		t.last = fin;
		pending_tokens.push_back(t);
	endtask

	// advance the scanner by one character and queue the tokens it closes
	task automatic scan_char(input logic [7:0] c);
		bit keep;
		keep = 1'b0;
		if (lex_mode == MODE_SKIP) begin
			if (c == CH_NUL)
				clear_scan();
			else if (lex_pos != '1)
				lex_pos++;
			return;
		end
		case (lex_mode)
			MODE_NAME: begin
				if (is_word_start(c) || is_digit(c))
					keep = 1'b1;
				else
					push_token(KIND_NAME, lex_begin, lex_pos - lex_begin, lex_head, 1'b0);
			end
			MODE_INT: begin
				if (is_digit(c)) begin
					keep = 1'b1;
				end else if (c == CH_DOT) begin
					lex_mode = MODE_FRAC;
					keep = 1'b1;
				end else begin
					push_token(KIND_NUMBER, lex_begin, lex_pos - lex_begin, lex_head, 1'b0);
				end
			end
			MODE_FRAC: begin
				if (is_digit(c))
					keep = 1'b1;
				else
					push_token(KIND_NUMBER, lex_begin, lex_pos - lex_begin, lex_head, 1'b0);
			end
			default: ;
		endcase
		if (!keep) begin
			lex_mode = MODE_IDLE;
			if (c == CH_NUL) begin
				push_token(KIND_END, lex_pos, 16'd1, CH_NUL, 1'b1);
				clear_scan();
				return;
			end else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
				// separator only
			end else if (c == CH_LPAREN) begin
				push_token(KIND_LPAREN, lex_pos, 16'd1, c, 1'b0);
			end else if (c == CH_RPAREN) begin
				push_token(KIND_RPAREN, lex_pos, 16'd1, c, 1'b0);
			end else if (c == CH_COMMA) begin
				push_token(KIND_COMMA, lex_pos, 16'd1, c, 1'b0);
			end else if (is_operator(c)) begin
				push_token(KIND_SYMBOL, lex_pos, 16'd1, c, 1'b0);
			end else if (is_word_start(c)) begin
				lex_mode = MODE_NAME;
				lex_begin = lex_pos;
				lex_head = c;
			end else if (is_digit(c)) begin
				lex_mode = MODE_INT;
				lex_begin = lex_pos;
				lex_head = c;
			end else begin
				push_token(KIND_UNKNOWN, lex_pos, 16'd1, c, 1'b1);
				lex_mode = MODE_SKIP;
			end
		end
		if (lex_pos != '1)
			lex_pos++;
	endtask

	// drive one character beat, bursts separated by random gaps
	task automatic send_char(input logic [7:0] c);
		if (burst_left == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(100, 300);
			else
				burst_left = $urandom_range(1, 32);
		end
		char_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (char_stall);
		burst_left--;
		if (lex_mode != MODE_SKIP)
			lexed_chars++;
		scan_char(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// random character pickers
	function automatic logic [7:0] word_char(input bit body);
		int r;
		r = $urandom_range(0, body ? 62 : 52);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		else if (r == 52)
			return CH_UNDER;
		else
			return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] digit_char();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
	endfunction

	function automatic logic [7:0] operator_char();
		case ($urandom_range(0, 7))
			0: return CH_PLUS;
			1: return CH_STAR;
			2: return CH_MINUS;
			3: return CH_SLASH;
			4: return CH_EQUAL;
			5: return CH_BAR;
			6: return CH_AMP;
			default: return CH_TILDE;
		endcase
	endfunction

	// every operator, both parentheses and the comma
	task automatic test_single_tokens();
		send_text("(+*-/=|&~),");
		send_char(CH_NUL);
	endtask

	// names, fractions, a dot ending a number and a name closed by the nul
	task automatic test_names_and_numbers();
		send_text("a_9\t3.5 7.Z");
		send_char(CH_NUL);
	endtask

	// unknown bytes, high bytes dropped in skip mode, nul in skip mode
	task automatic test_unknown_bytes();
		send_char(8'hFF);
		send_char(8'h80);
		send_char(8'h7F);
		send_char(CH_NUL);
		send_char(8'h7F);
		send_char(CH_NUL);
	endtask

	// random expressions, some noise and stray nuls
	task automatic test_random_expressions(input int count);
		int base;
		int len;
		int r;
		base = lexed_chars;
		while (lexed_chars - base < count) begin
			repeat ($urandom_range(1, 20)) begin
				r = $urandom_range(0, 99);
				if (r < 28) begin
					send_char(word_char(1'b0));
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
					repeat (len) send_char(word_char(1'b1));
				end else if (r < 52) begin
					repeat ($urandom_range(1, 5)) send_char(digit_char());
					if ($urandom_range(0, 9) < 4) begin
						send_char(CH_DOT);
						repeat ($urandom_range(0, 4)) send_char(digit_char());
					end
				end else if (r < 68) begin
					send_char(operator_char());
				end else if (r < 78) begin
					send_char($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
				end else if (r < 82) begin
					send_char(CH_COMMA);
				end else if (r < 92) begin
					repeat ($urandom_range(1, 3)) send_char(space_char());
				end else begin
					send_char(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 99) < 35)
					send_char(space_char());
			end
			send_char(CH_NUL);
		end
	endtask

	// a name of 301 characters, then a symbol, a one-letter name and a number closed by the nul
	task automatic test_long_string();
		send_char(word_char(1'b0));
		repeat (300) send_char(word_char(1'b1));
		send_text("+q 5.");
		send_char(CH_NUL);
	endtask

	// receiver stall pattern: free, light, heavy, periodic
	always @(posedge clk) begin
		stall_tick <= stall_tick + 10'd1;
		case (stall_tick[9:8])
			2'd0: token_stall <= 1'b0;
			2'd1: token_stall <= ($urandom_range(0, 3) == 0);
			2'd2: token_stall <= ($urandom_range(0, 3) != 0);
			default: token_stall <= (stall_tick[2:0] != 3'd0);
		endcase
	end

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			// keep the log short when the block is badly broken
			if (errors <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// compare each token beat with the oldest queued token
	always @(posedge clk) begin
		token_t t;
		if (arst_n && token_valid && !token_stall) begin
			if (pending_tokens.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected token, expected none, actual kind %0d start %0d",
						$time, token_kind, token_start);
			end else begin
				t = pending_tokens.pop_front();
				check_field("token_kind", int'(t.kind), int'(token_kind));
				check_field("token_start", int'(t.start), int'(token_start));
				check_field("token_length", int'(t.length), int'(token_length));
				check_field("first_byte", int'(t.head), int'(first_byte));
				check_field("last", int'(t.last), int'(last));
			end
		end
	end

	// end the run when neither side moves for too long
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (token_valid && !token_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_tokens();
		test_names_and_numbers();
		test_unknown_bytes();
		test_random_expressions(900);
		test_long_string();
		char_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/etok_pkg.sv
sv/etok_lex.sv
sv/etok_queue.sv
sv/expression_tokenizer.sv
sim/expression_tokenizer_test.sv
